>>> hdl/fft_pkg.sv
// Shared types, constants and elaboration-time twiddle math for the radix-2 frame FFT.
// No dependencies; used by every module of the block.
`default_nettype none
package fft_pkg;

   localparam int POINTS_DEF   = 512;
   localparam int TWIDDLE_DEF  = 16;
   localparam int SAMPLE_W     = 16;
   localparam int WIDE         = 26;
   localparam int BIN_W        = 9;
   localparam int RSP_DATA_W   = 64;
   localparam int QUEUE_DEPTH  = 4;

   localparam longint TWO_PI_Q30 = 64'sd6746518852;
   localparam longint ONE_Q30    = 64'sd1073741824;

   typedef enum logic [1:0] {
      CMD_LOAD      = 2'd0,
      CMD_LOAD_LAST = 2'd1,
      CMD_READ      = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [SAMPLE_W-1:0] sample;
   } cmd_type;

   // Shift-subtract quotient for non-negative operands (elaboration use only).
   function automatic longint udiv(longint num, longint den);
      longint rem;
      longint quo;
      rem = 0;
      quo = 0;
      for (int i = 62; i >= 0; i--) begin
         rem = (rem <<< 1) | ((num >>> i) & 64'sd1);
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | (64'sd1 <<< i);
         end
      end
      return quo;
   endfunction

   // Twiddle W(k) real or imaginary part, signed with frac fractional bits.
   function automatic longint tw_value(int k, int log2p, int frac, bit want_im);
      longint term;
      longint cs;
      longint sn;
      longint x;
      longint qc;
      longint qs;
      longint top;
      int     points;
      int     m;
      bit     mirror;
      points = 1 << log2p;
      mirror = (4 * k) > points;
      m      = mirror ? ((points >> 1) - k) : k;
      x      = (longint'(m) * TWO_PI_Q30) >>> log2p;
      term   = ONE_Q30;
      cs     = 0;
      sn     = 0;
      for (int n = 0; n < 24; n++) begin
         if (n > 0) term = udiv((term * x) >>> 30, longint'(n));
         case (n & 3)
            0:       cs = cs + term;
            1:       sn = sn + term;
            2:       cs = cs - term;
            default: sn = sn - term;
         endcase
      end
      if (cs < 0) cs = 0;
      if (sn < 0) sn = 0;
      top = (64'sd1 <<< frac) - 1;
      qc  = (cs + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
      qs  = (sn + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
      if (qc > top) qc = top;
      if (qs > top) qs = top;
      if (want_im) return -qs;
      return mirror ? -qc : qc;
   endfunction

endpackage
`default_nettype wire

>>> hdl/fft_front.sv
// Front end: accepts request transfers, classifies them and queues commands.
// Depends on fft_pkg.
`default_nettype none
module fft_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [fft_pkg::SAMPLE_W-1:0] req_tdata,
   input  wire                          req_tuser,
   input  wire                          req_tlast,
   output logic                         cmd_valid,
   output fft_pkg::cmd_type             cmd,
   input  wire                          cmd_pop
);
   import fft_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   cmd_type          queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   cmd_type          new_cmd;
   logic             push;

   // classify the incoming transfer
   always_comb begin
      new_cmd.sample = req_tdata;
      if (req_tuser) begin
         new_cmd.kind = CMD_READ;
      end else if (req_tlast) begin
         new_cmd.kind = CMD_LOAD_LAST;
      end else begin
         new_cmd.kind = CMD_LOAD;
      end
   end

   assign req_tready = count_ff != (PTR_W+1)'(QUEUE_DEPTH);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = count_ff != '0;
   assign cmd        = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) queue_ff[wr_ptr_ff] <= new_cmd;
   end

endmodule
`default_nettype wire

>>> hdl/fft_back.sv
// Back end: frame store, zero pad sweep, butterfly sequencer and result register.
// Depends on fft_pkg.
`default_nettype none
module fft_back #(
   parameter int POINTS       = fft_pkg::POINTS_DEF,
   parameter int TWIDDLE_BITS = fft_pkg::TWIDDLE_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            cmd_valid,
   input  fft_pkg::cmd_type               cmd,
   output logic                           cmd_pop,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [fft_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);
   import fft_pkg::*;

   localparam int ADDR  = $clog2(POINTS);
   localparam int HALF  = POINTS / 2;
   localparam int STG_W = (ADDR > 1) ? $clog2(ADDR) : 1;
   localparam int TW    = TWIDDLE_BITS;
   localparam int FRAC  = TWIDDLE_BITS - 1;
   localparam int PW    = WIDE + TWIDDLE_BITS;
   localparam int MW    = 2 * WIDE;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_RD     = 7'b0000010,
      ST_PAD    = 7'b0000100,
      ST_BF_RD  = 7'b0001000,
      ST_BF_MUL = 7'b0010000,
      ST_BF_SUM = 7'b0100000,
      ST_BF_WO  = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [ADDR:0]    load_count_ff, load_count_in;
   logic [ADDR-1:0]  rp_ff, rp_in;
   logic             ready_ff, ready_in;
   logic [STG_W-1:0] stage_ff, stage_in;
   logic [ADDR-1:0]  bfly_ff, bfly_in;
   logic [ADDR:0]    pad_ff, pad_in;

   logic [MW-1:0]    mem [POINTS];
   logic             we;
   logic [ADDR-1:0]  waddr;
   logic [MW-1:0]    wdata;
   logic             rd_en;
   logic [ADDR-1:0]  raddr_a, raddr_b;
   logic [MW-1:0]    rd_a_ff, rd_b_ff;

   logic signed [TW-1:0] tw_re_tab [POINTS];
   logic signed [TW-1:0] tw_im_tab [POINTS];

   logic [ADDR-1:0]  a_addr, o_addr, k_idx, low_mask;
   logic [ADDR-1:0]  a_addr_ff, o_addr_ff;
   logic             kzero_ff;
   logic signed [TW-1:0] twr_ff, twi_ff;
   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [WIDE-1:0] ar_ff, ai_ff, br_ff, bi_ff;
   logic signed [WIDE-1:0] tr, ti;
   logic [MW-1:0]    sum_o_ff, sum_o_in;

   logic             out_free;
   logic             rsp_load_zero, rsp_load_bin;
   logic [ADDR:0]    next_count;
   logic [ADDR-1:0]  load_rev, pad_rev;

   function automatic logic [ADDR-1:0] bit_rev(logic [ADDR-1:0] v);
      logic [ADDR-1:0] r;
      for (int b = 0; b < ADDR; b++) r[ADDR-1-b] = v[b];
      return r;
   endfunction

   function automatic logic signed [WIDE-1:0] round_prod(logic signed [PW-1:0] p);
      logic signed [PW-1:0] q;
      q = (p + (PW'(1) <<< (FRAC - 1))) >>> FRAC;
      return q[WIDE-1:0];
   endfunction

   for (genvar g = 0; g < POINTS; g++) begin : g_tw
      if (g < HALF) begin : g_live
         assign tw_re_tab[g] = TW'(tw_value(g, ADDR, FRAC, 1'b0));
         assign tw_im_tab[g] = TW'(tw_value(g, ADDR, FRAC, 1'b1));
      end else begin : g_unused
         assign tw_re_tab[g] = '0;
         assign tw_im_tab[g] = '0;
      end
   end

   // butterfly addressing for the current stage and butterfly number
   always_comb begin
      low_mask = (ADDR'(1) << stage_ff) - 1'b1;
      a_addr   = ADDR'((((ADDR+1)'(bfly_ff)) >> stage_ff) << (stage_ff + 1'b1))
                 | (bfly_ff & low_mask);
      o_addr   = a_addr | (ADDR'(1) << stage_ff);
      k_idx    = ADDR'((bfly_ff & low_mask) << (ADDR'(ADDR - 1) - ADDR'(stage_ff)));
   end

   assign out_free   = !rsp_tvalid || rsp_tready;
   assign next_count = load_count_ff + 1'b1;
   assign load_rev   = bit_rev(load_count_ff[ADDR-1:0]);
   assign pad_rev    = bit_rev(pad_ff[ADDR-1:0]);

   // twiddled odd input; unity twiddle passes it through exactly
   always_comb begin
      if (kzero_ff) begin
         tr = br_ff;
         ti = bi_ff;
      end else begin
         tr = round_prod(p_rr_ff) - round_prod(p_ii_ff);
         ti = round_prod(p_ir_ff) + round_prod(p_ri_ff);
      end
      sum_o_in = {ai_ff - ti, ar_ff - tr};
   end

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      rp_in         = rp_ff;
      ready_in      = ready_ff;
      stage_in      = stage_ff;
      bfly_in       = bfly_ff;
      pad_in        = pad_ff;
      cmd_pop       = 1'b0;
      we            = 1'b0;
      waddr         = a_addr_ff;
      wdata         = {ai_ff + ti, ar_ff + tr};
      rd_en         = 1'b0;
      raddr_a       = a_addr;
      raddr_b       = o_addr;
      rsp_load_zero = 1'b0;
      rsp_load_bin  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.kind)
                  CMD_READ: begin
                     if (out_free) begin
                        cmd_pop = 1'b1;
                        if (ready_ff) begin
                           rd_en    = 1'b1;
                           raddr_a  = rp_ff;
                           state_in = ST_RD;
                        end else begin
                           rsp_load_zero = 1'b1;
                        end
                     end
                  end
                  CMD_LOAD, CMD_LOAD_LAST: begin
                     cmd_pop = 1'b1;
                     // drop loads while a finished frame waits
                     if (!ready_ff) begin
                        we    = 1'b1;
                        waddr = load_rev;
                        wdata = {{WIDE{1'b0}},
                                 {(WIDE-SAMPLE_W){cmd.sample[SAMPLE_W-1]}}, cmd.sample};
                        load_count_in = next_count;
                        if (next_count == (ADDR+1)'(POINTS)) begin
                           stage_in = '0;
                           bfly_in  = '0;
                           state_in = ST_BF_RD;
                        end else if (cmd.kind == CMD_LOAD_LAST) begin
                           pad_in   = next_count;
                           state_in = ST_PAD;
                        end
                     end
                  end
                  default: cmd_pop = 1'b1;
               endcase
            end
         end
         ST_RD: begin
            rsp_load_bin = 1'b1;
            if (rp_ff == ADDR'(POINTS - 1)) begin
               ready_in      = 1'b0;
               rp_in         = '0;
               load_count_in = '0;
            end else begin
               rp_in = rp_ff + 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_PAD: begin
            we    = 1'b1;
            waddr = pad_rev;
            wdata = '0;
            if (pad_ff == (ADDR+1)'(POINTS - 1)) begin
               stage_in = '0;
               bfly_in  = '0;
               state_in = ST_BF_RD;
            end else begin
               pad_in = pad_ff + 1'b1;
            end
         end
         ST_BF_RD: begin
            rd_en    = 1'b1;
            state_in = ST_BF_MUL;
         end
         ST_BF_MUL: state_in = ST_BF_SUM;
         ST_BF_SUM: begin
            we       = 1'b1;
            state_in = ST_BF_WO;
         end
         ST_BF_WO: begin
            we    = 1'b1;
            waddr = o_addr_ff;
            wdata = sum_o_ff;
            if (bfly_ff == ADDR'(HALF - 1)) begin
               bfly_in = '0;
               if (stage_ff == STG_W'(ADDR - 1)) begin
                  ready_in = 1'b1;
                  rp_in    = '0;
                  state_in = ST_IDLE;
               end else begin
                  stage_in = stage_ff + 1'b1;
                  state_in = ST_BF_RD;
               end
            end else begin
               bfly_in  = bfly_ff + 1'b1;
               state_in = ST_BF_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         load_count_ff <= '0;
         rp_ff         <= '0;
         ready_ff      <= 1'b0;
         stage_ff      <= '0;
         bfly_ff       <= '0;
         pad_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         rp_ff         <= rp_in;
         ready_ff      <= ready_in;
         stage_ff      <= stage_in;
         bfly_ff       <= bfly_in;
         pad_ff        <= pad_in;
      end
   end

   // frame store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (rd_en) begin
         rd_a_ff <= mem[raddr_a];
         rd_b_ff <= mem[raddr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_BF_RD) begin
         a_addr_ff <= a_addr;
         o_addr_ff <= o_addr;
         kzero_ff  <= k_idx == '0;
         twr_ff    <= tw_re_tab[k_idx];
         twi_ff    <= tw_im_tab[k_idx];
      end
      if (state_ff == ST_BF_MUL) begin
         ar_ff   <= rd_a_ff[WIDE-1:0];
         ai_ff   <= rd_a_ff[MW-1:WIDE];
         br_ff   <= rd_b_ff[WIDE-1:0];
         bi_ff   <= rd_b_ff[MW-1:WIDE];
         p_rr_ff <= $signed(rd_b_ff[WIDE-1:0]) * twr_ff;
         p_ii_ff <= $signed(rd_b_ff[MW-1:WIDE]) * twi_ff;
         p_ri_ff <= $signed(rd_b_ff[MW-1:WIDE]) * twr_ff;
         p_ir_ff <= $signed(rd_b_ff[WIDE-1:0]) * twi_ff;
      end
      if (state_ff == ST_BF_SUM) sum_o_ff <= sum_o_in;
   end

   // result register; tdata = valid_res, bin_index, real_part, imag_part, zero fill
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (rsp_load_zero || rsp_load_bin) begin
         rsp_tvalid <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load_zero) begin
         rsp_tdata <= '0;
         rsp_tlast <= 1'b0;
      end else if (rsp_load_bin) begin
         rsp_tdata <= {{(RSP_DATA_W - 1 - BIN_W - MW){1'b0}},
                       rd_a_ff[MW-1:WIDE], rd_a_ff[WIDE-1:0], BIN_W'(rp_ff), 1'b1};
         rsp_tlast <= rp_ff == ADDR'(POINTS - 1);
      end
   end

endmodule
`default_nettype wire

>>> hdl/radix2_fft_frame.sv
// Top level of the radix-2 decimation-in-time frame FFT.
// Depends on fft_pkg, fft_front and fft_back.
//
// req channel: tuser = action (0 load a sample, 1 read the next bin),
//   tdata = signed 16-bit sample, tlast = last sample of the frame.
// rsp channel: one transfer per read; tlast marks bin POINTS-1.
// A load flagged last, or the POINTS-th load, zero-pads the frame and
// starts the transform. Loads that arrive while a finished frame waits
// are dropped. A read before the transform is done returns valid_res 0.
// A four-entry command queue decouples the request side from the engine.
// Loads retire one per cycle while the engine is idle, not during the pad
// sweep or transform. A read waits for a free result register; for a ready
// frame it passes through the read state before its bin is registered,
// else its zero result is registered directly. The transform pads the
// POINTS - n entries left after n loads, then runs (POINTS/2) * log2(POINTS)
// butterflies: each reads both operands through the two store read ports,
// multiplies, then writes the two results through the single write port.
// Reset clears the queue, counters and result valid flag; the store keeps
// stale data until loads and the pad sweep overwrite it.
// On a receiver stall, hold the result; requests queue until the queue fills.
`default_nettype none
module radix2_fft_frame #(
   parameter int POINTS       = fft_pkg::POINTS_DEF,
   parameter int TWIDDLE_BITS = fft_pkg::TWIDDLE_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   input  wire  [fft_pkg::SAMPLE_W-1:0]   req_tdata,  // sample
   input  wire                            req_tuser,  // action
   input  wire                            req_tlast,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [fft_pkg::RSP_DATA_W-1:0] rsp_tdata,  // valid_res, bin_index, real, imag
   output logic                           rsp_tlast
);
   import fft_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;

   // accept and classify each transfer into the command queue
   fft_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   // execute loads, transforms and reads against the frame store
   fft_back #(
      .POINTS       (POINTS),
      .TWIDDLE_BITS (TWIDDLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

>>> hdl/fft_checker.sv
// Port-level checks for radix2_fft_frame, attached by bind.
// Depends on fft_pkg.
`default_nettype none
module fft_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            rsp_tvalid,
   input wire                            rsp_tready,
   input wire [fft_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire                            rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_not_ready_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata == '0 && !rsp_tlast)
      else $error("not-ready result carries data");

   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[0])
      else $error("last bin without valid data");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind radix2_fft_frame fft_checker u_fft_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

>>> dv/radix2_fft_frame_tb.sv
// Self-checking testbench for radix2_fft_frame: loads frames, reads bins, predicts every bin.
// Depends on fft_pkg and the radix2_fft_frame RTL; needs no other files.
`timescale 1ns / 1ps
module radix2_fft_frame_tb;
   import fft_pkg::*;

   localparam int  NPTS      = POINTS_DEF;
   localparam int  LOG2N     = $clog2(NPTS);
   localparam int  FRACB     = TWIDDLE_DEF - 1;
   localparam bit  ACT_LOAD  = 1'b0;
   localparam bit  ACT_READ  = 1'b1;
   localparam int  PHASE_LEN = 200;
   localparam int  PEEK_BINS = 16;

   // One returned bin as the block should present it.
   typedef struct {
      bit               ok;
      logic [BIN_W-1:0] bin;
      logic [WIDE-1:0]  re;
      logic [WIDE-1:0]  im;
      bit               last;
   } bin_result_type;

   // Bin predictor plus queue of bins still owed by the block.
   class fft_scoreboard_type;
      longint          bin_re[NPTS];
      longint          bin_im[NPTS];
      longint          w_re[NPTS/2];
      longint          w_im[NPTS/2];
      int unsigned     samples_in;
      int unsigned     next_bin;
      bit              frame_done;
      bin_result_type  owed[$];
      int unsigned     errors;
      int unsigned     checked;
      int unsigned     transforms;

      function new();
         longint term, cs, sn, x, qc, qs, top;
         int     m;
         bit     mirror;
         top = (64'sd1 <<< FRACB) - 1;
         for (int k = 0; k < NPTS/2; k++) begin
            mirror = 4 * k > NPTS;
            m      = mirror ? NPTS/2 - k : k;
            x      = longint'(m) * TWO_PI_Q30 / NPTS;
            term   = ONE_Q30;
            cs     = 0;
            sn     = 0;
            // Taylor series in Q30, terms alternate between cos and sin
            for (int n = 0; n < 24; n++) begin
               if (n > 0) term = ((term * x) >>> 30) / n;
               case (n % 4)
                  0:       cs += term;
                  1:       sn += term;
                  2:       cs -= term;
                  default: sn -= term;
               endcase
            end
            if (cs < 0) cs = 0;
            if (sn < 0) sn = 0;
            qc = (cs + (64'sd1 <<< (29 - FRACB))) >>> (30 - FRACB);
            qs = (sn + (64'sd1 <<< (29 - FRACB))) >>> (30 - FRACB);
            if (qc > top) qc = top;
            if (qs > top) qs = top;
            w_re[k] = mirror ? -qc : qc;
            w_im[k] = -qs;
         end
      endfunction

      function longint wrap26(longint v);
         logic signed [WIDE-1:0] t;
         t = v[WIDE-1:0];
         return longint'(t);
      endfunction

      // Product rounded half up; arithmetic shift floors.
      function longint rmul(longint a, longint b);
         return (a * b + (64'sd1 <<< (FRACB - 1))) >>> FRACB;
      endfunction

      function void run_fft();
         int     r, a, o, hlf, stp, k;
         longint t, tr, ti;
         for (int i = 0; i < NPTS; i++) begin
            r = 0;
            for (int b = 0; b < LOG2N; b++) if (i[b]) r |= 1 << (LOG2N - 1 - b);
            if (i < r) begin
               t = bin_re[i]; bin_re[i] = bin_re[r]; bin_re[r] = t;
               t = bin_im[i]; bin_im[i] = bin_im[r]; bin_im[r] = t;
            end
         end
         for (int len = 2; len <= NPTS; len *= 2) begin
            hlf = len / 2;
            stp = NPTS / len;
            for (int base = 0; base < NPTS; base += len) begin
               for (int j = 0; j < hlf; j++) begin
                  a = base + j;
                  o = a + hlf;
                  k = j * stp;
                  // unity twiddle passes the odd input through untouched
                  if (k == 0) begin
                     tr = bin_re[o];
                     ti = bin_im[o];
                  end else begin
                     tr = rmul(bin_re[o], w_re[k]) - rmul(bin_im[o], w_im[k]);
                     ti = rmul(bin_re[o], w_im[k]) + rmul(bin_im[o], w_re[k]);
                  end
                  bin_re[o] = wrap26(bin_re[a] - tr);
                  bin_im[o] = wrap26(bin_im[a] - ti);
                  bin_re[a] = wrap26(bin_re[a] + tr);
                  bin_im[a] = wrap26(bin_im[a] + ti);
               end
            end
         end
         transforms++;
      endfunction

      // Note one accepted request transfer.
      function void note_request(bit act, logic [SAMPLE_W-1:0] smp, bit fin);
         bin_result_type e;
         if (act == ACT_LOAD) begin
            // drop loads while a finished frame waits
            if (frame_done || samples_in >= NPTS) return;
            bin_re[samples_in] = longint'($signed(smp));
            bin_im[samples_in] = 0;
            samples_in++;
            if (fin || samples_in >= NPTS) begin
               for (int i = samples_in; i < NPTS; i++) begin
                  bin_re[i] = 0;
                  bin_im[i] = 0;
               end
               run_fft();
               frame_done = 1;
               next_bin   = 0;
            end
            return;
         end
         e = '{ok: 0, bin: '0, re: '0, im: '0, last: 0};
         if (frame_done) begin
            e.ok   = 1;
            e.bin  = next_bin[BIN_W-1:0];
            e.re   = bin_re[next_bin][WIDE-1:0];
            e.im   = bin_im[next_bin][WIDE-1:0];
            e.last = next_bin == NPTS - 1;
            if (e.last) begin
               frame_done = 0;
               next_bin   = 0;
               samples_in = 0;
            end else begin
               next_bin++;
            end
         end
         owed.insert(owed.size(), e);
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         $display("[%0t] rsp %s: got %0h expected %0h", $realtime, what, got, want);
      endtask

      // Check one accepted response transfer against the oldest owed bin.
      task check_response(logic [RSP_DATA_W-1:0] d, bit lst);
         bin_result_type e;
         if (owed.size() == 0) begin
            report("with nothing owed", d, 0);
            return;
         end
         e = owed.pop_front();
         checked++;
         if (d[0] !== e.ok)        report("valid_res", d[0], e.ok);
         if (d[9:1] !== e.bin)     report("bin_index", d[9:1], e.bin);
         if (d[35:10] !== e.re)    report("real_part", d[35:10], e.re);
         if (d[61:36] !== e.im)    report("imag_part", d[61:36], e.im);
         if (lst !== e.last)       report("tlast", lst, e.last);
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata;   // sample
   logic                  req_tuser;   // action
   logic                  req_tlast;   // final_sample
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // valid_res, bin_index, real_part, imag_part, zero pad
   logic                  rsp_tlast;   // last_bin

   fft_scoreboard_type sb;
   int unsigned   send_idle_pct;
   int unsigned   recv_stall_pct;
   int unsigned   sent_items;
   int unsigned   frames;

   radix2_fft_frame DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit: well above the slowest legal run.
   initial begin
      #15ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Receiver: check on every response transfer, stall at random.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tlast);
         rsp_tready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   task set_phase(int p);
      case (p % 4)
         0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1:       begin send_idle_pct = 51; recv_stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  recv_stall_pct = 51; end
         default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
   endtask

   // Present one request and hold it until the transfer completes.
   task send(bit act, logic [SAMPLE_W-1:0] smp, bit fin);
      set_phase(int'(sent_items / PHASE_LEN));
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= smp;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      sb.note_request(act, smp, fin);
      sent_items++;
   endtask

   // Read out a whole frame; tlast on reads is noise and must be ignored.
   task read_frame();
      for (int i = 0; i < NPTS; i++) send(ACT_READ, SAMPLE_W'($urandom), 1'($urandom_range(1)));
      frames++;
   endtask

   initial begin
      int n;
      sb             = new();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      sent_items     = 0;
      frames         = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = ACT_LOAD;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reads before any frame.
      send(ACT_READ, 16'h1234, 1'b0);
      send(ACT_READ, 16'hFFFF, 1'b1);
      // Full frame that starts on count alone, sample extremes first.
      send(ACT_LOAD, 16'h7FFF, 1'b0);
      send(ACT_LOAD, 16'h8000, 1'b0);
      send(ACT_LOAD, 16'h0000, 1'b0);
      send(ACT_LOAD, 16'hFFFF, 1'b0);
      send(ACT_LOAD, 16'h0001, 1'b0);
      for (int i = 5; i < NPTS; i++) send(ACT_LOAD, SAMPLE_W'($urandom), 1'b0);
      // loads while the finished frame waits are dropped
      send(ACT_LOAD, 16'h5555, 1'b1);
      send(ACT_LOAD, 16'hAAAA, 1'b0);
      read_frame();

      // hold off until the block has returned everything owed
      req_tvalid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);

      // Short frame closed by the final flag and zero padded; read its leading bins.
      send(ACT_LOAD, 16'h8000, 1'b0);
      n = $urandom_range(12, 1);
      for (int i = 0; i < n; i++) send(ACT_LOAD, SAMPLE_W'($urandom), i == n - 1);
      for (int i = 0; i < PEEK_BINS; i++)
         send(ACT_READ, SAMPLE_W'($urandom), 1'($urandom_range(1)));
      req_tvalid <= 1'b0;

      while (sb.owed.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Covered %0d request transfers, %0d full read-outs, %0d transforms, %0d responses.",
               sent_items, frames, sb.transforms, sb.checked);
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> radix2_fft_frame.f
hdl/fft_pkg.sv
hdl/fft_front.sv
hdl/fft_back.sv
hdl/radix2_fft_frame.sv
hdl/fft_checker.sv
dv/radix2_fft_frame_tb.sv
